[src/mavx_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mavx_pkg
// Shared types and constants of the moving average crossover detector.
// ----------------------------------------------------------------------------
package mavx_pkg;

	// Deepest long window. The ring is addressed modulo this depth, so it is
	// kept a power of two.
	localparam int MAX_LONG_WINDOW = 256;
	localparam int RING_AW         = $clog2(MAX_LONG_WINDOW);
	localparam int FILL_W          = $clog2(MAX_LONG_WINDOW + 1);

	localparam int PRICE_W = 32;
	localparam int SUM_W   = 40;
	localparam int TIME_W  = 64;
	localparam int SYM_W   = 16;
	localparam int SP_W    = 8;
	localparam int LP_W    = 9;
	localparam int PROD_W  = SUM_W + LP_W;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Result queue in front of the output port.
	localparam int OUT_DEPTH = 8;
	localparam int OUT_AW    = $clog2(OUT_DEPTH);
	localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SYMBOL = 2'd0,
		CFG_SHORT  = 2'd1,
		CFG_LONG   = 2'd2
	} cfg_idx_t;

	localparam logic OP_HISTORY = 1'b0;
	localparam logic OP_LIVE    = 1'b1;

	localparam logic DIR_BUY  = 1'b0;
	localparam logic DIR_SELL = 1'b1;

	typedef struct packed {
		logic [TIME_W-1:0] stamp;
		logic              dir;
	} result_t;

endpackage
`default_nettype wire

[src/mavx_ring.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mavx_ring
// Price ring: one write port and two registered read ports.
// ----------------------------------------------------------------------------
module mavx_ring import mavx_pkg::*; (
	input  wire logic               clk,
	input  wire logic               wr_en,
	input  wire logic [RING_AW-1:0] wr_addr,
	input  wire logic [PRICE_W-1:0] wr_data,
	input  wire logic [RING_AW-1:0] rd_addr_a,
	input  wire logic [RING_AW-1:0] rd_addr_b,
	output logic      [PRICE_W-1:0] rd_data_a,
	output logic      [PRICE_W-1:0] rd_data_b
);

	logic [PRICE_W-1:0] mem_q [MAX_LONG_WINDOW];

	// A read of the entry being written returns the old contents.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_a <= mem_q[rd_addr_a];
		rd_data_b <= mem_q[rd_addr_b];
	end

endmodule
`default_nettype wire

[src/mavx_out_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mavx_out_fifo
// Small result queue that decouples the pipeline from the output receiver.
// ----------------------------------------------------------------------------
module mavx_out_fifo import mavx_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire result_t           push_data,
	input  wire logic              pop,
	output result_t                head,
	output logic                   not_empty,
	output logic      [OUT_CW-1:0] count
);

	result_t           mem_q [OUT_DEPTH];
	logic [OUT_AW-1:0] wr_ptr_q;
	logic [OUT_AW-1:0] rd_ptr_q;
	logic [OUT_CW-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + OUT_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OUT_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + OUT_CW'(1);
			end else if (!push && pop) begin
				count_q <= count_q - OUT_CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	assign head      = mem_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign count     = count_q;

endmodule
`default_nettype wire

[src/moving_average_crossover_detector.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// moving_average_crossover_detector
// Short and long simple moving averages over one symbol's closes, with a
// buy or sell beat whenever the short mean crosses the long mean on a live bar.
// ----------------------------------------------------------------------------
// Usage:
// Bars enter on the in channel (valid/ready); one bar is taken per cycle for
// as long as the result queue has room. Bars of other symbols, and live bars
// before the long window has filled, leave no trace. A crossing on a live bar
// produces one beat on the out channel through the result queue.
// Each bar is a read, modify and write pass over the price ring: the two
// expired prices are read in the accept cycle, the sums are updated and the
// new price is written in the next, and the means are compared in stage 2.
// A price written by the bar just ahead is forwarded instead of read.
// The out channel is fronted by an eight-entry queue. When the receiver
// stalls, the queue fills and in_ready drops once the queue together with
// the bars in flight could fill it, so no result is ever dropped.
// Reset returns the registers to symbol 0, short period 10, long period 50,
// and empties the windows. A write to a known cfg register also empties the
// windows; cfg_ready is always high and writes are meant for idle periods.
// ----------------------------------------------------------------------------
module moving_average_crossover_detector import mavx_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// bar input
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  op,
	input  wire logic [SYM_W-1:0]      bar_symbol,
	input  wire logic [TIME_W-1:0]     bar_time,
	input  wire logic [PRICE_W-1:0]    close_price,
	// signal output
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic      [TIME_W-1:0]     signal_time,
	output logic      [SYM_W-1:0]      signal_symbol,
	output logic                       direction,
	// register writes
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	// Configuration registers.
	logic [SYM_W-1:0] sym_q;
	logic [SP_W-1:0]  sp_q;
	logic [LP_W-1:0]  lp_q;

	// Window state.
	logic [RING_AW-1:0] wp_q;
	logic [FILL_W-1:0]  fill_q;
	logic               warm_q;
	logic [SUM_W-1:0]   sum_short_q;
	logic [SUM_W-1:0]   sum_long_q;
	logic               above_q;

	// Stage 1: ring data arrives, sums update, price is written back.
	logic               v_s1;
	logic               upd_s1;
	logic               op_s1;
	logic [TIME_W-1:0]  time_s1;
	logic [PRICE_W-1:0] price_s1;
	logic [RING_AW-1:0] waddr_s1;
	logic               sub_short_s1;
	logic               sub_long_s1;
	logic               fwd_short_s1;
	logic               fwd_long_s1;
	logic [PRICE_W-1:0] fwd_data_s1;

	// Stage 2: compare the means, emit on a crossing.
	logic               v_s2;
	logic               upd_s2;
	logic               op_s2;
	logic [TIME_W-1:0]  time_s2;

	logic               cfg_fire;
	logic               cfg_restart;
	logic               in_fire;
	logic               periods_ok;
	logic               in_upd;
	logic [RING_AW-1:0] rd_short;
	logic [RING_AW-1:0] rd_long;
	logic [FILL_W-1:0]  fill_next;
	logic [PRICE_W-1:0] ring_short;
	logic [PRICE_W-1:0] ring_long;
	logic [PRICE_W-1:0] old_short;
	logic [PRICE_W-1:0] old_long;
	logic [PROD_W-1:0]  prod_short;
	logic [PROD_W-1:0]  prod_long;
	logic               now_above;
	logic               res_push;
	result_t            res_data;
	result_t            res_head;
	logic               res_pop;
	logic [OUT_CW-1:0]  res_count;

	// ------------------------------------------------------------------
	// Configuration port. Every write to a known register also restarts
	// the windows so that the sums always belong to the periods in use.
	// ------------------------------------------------------------------
	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;

	always_comb begin
		cfg_restart = 1'b0;
		if (cfg_fire) begin
			case (cfg_index)
				CFG_SYMBOL: cfg_restart = 1'b1;
				CFG_SHORT:  cfg_restart = 1'b1;
				CFG_LONG:   cfg_restart = 1'b1;
				default:    cfg_restart = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sym_q <= '0;
			sp_q  <= SP_W'(10);
			lp_q  <= LP_W'(50);
		end else if (cfg_fire) begin
			case (cfg_index)
				CFG_SYMBOL: sym_q <= cfg_data[SYM_W-1:0];
				CFG_SHORT:  sp_q  <= cfg_data[SP_W-1:0];
				CFG_LONG:   lp_q  <= cfg_data[LP_W-1:0];
				default:    ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Accept. The queue must be able to absorb a result from every bar in
	// flight plus the one being taken.
	// ------------------------------------------------------------------
	assign in_ready = (int'(res_count) + int'(v_s1) + int'(v_s2)) < OUT_DEPTH;
	assign in_fire  = in_valid && in_ready;

	// Periods are usable only with 1 <= short < long <= ring depth.
	assign periods_ok = (sp_q != '0) && (LP_W'(sp_q) < lp_q)
		&& (int'(lp_q) <= MAX_LONG_WINDOW);

	assign in_upd = (bar_symbol == sym_q) && periods_ok
		&& !((op == OP_LIVE) && !warm_q);

	// Ring slots of the prices that leave the two windows.
	assign rd_short  = wp_q - RING_AW'(sp_q);
	assign rd_long   = wp_q - RING_AW'(lp_q);
	assign fill_next = (int'(fill_q) < MAX_LONG_WINDOW) ? fill_q + FILL_W'(1) : fill_q;

	// Pointer, fill level and warm-up flag need no ring data, so they move
	// at the accept edge and the next bar sees them at once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			fill_q <= '0;
			warm_q <= 1'b0;
		end else if (cfg_restart) begin
			wp_q   <= '0;
			fill_q <= '0;
			warm_q <= 1'b0;
		end else if (in_fire && in_upd) begin
			wp_q   <= wp_q + RING_AW'(1);
			fill_q <= fill_next;
			if ((op == OP_HISTORY) && (int'(fill_next) >= int'(lp_q))) begin
				warm_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= in_fire;
			v_s2 <= v_s1;
		end
	end

	// The bar now in stage 1 writes its price at the same edge at which the
	// new bar reads the ring, so a matching slot is taken from the register.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			upd_s1       <= in_upd;
			op_s1        <= op;
			time_s1      <= bar_time;
			price_s1     <= close_price;
			waddr_s1     <= wp_q;
			sub_short_s1 <= int'(fill_q) >= int'(sp_q);
			sub_long_s1  <= int'(fill_q) >= int'(lp_q);
			fwd_short_s1 <= v_s1 && upd_s1 && (waddr_s1 == rd_short);
			fwd_long_s1  <= v_s1 && upd_s1 && (waddr_s1 == rd_long);
			fwd_data_s1  <= price_s1;
		end
		upd_s2  <= upd_s1;
		op_s2   <= op_s1;
		time_s2 <= time_s1;
	end

	// ------------------------------------------------------------------
	// Price ring.
	// ------------------------------------------------------------------
	mavx_ring u_ring (
		.clk       (clk),
		.wr_en     (v_s1 && upd_s1),
		.wr_addr   (waddr_s1),
		.wr_data   (price_s1),
		.rd_addr_a (rd_short),
		.rd_addr_b (rd_long),
		.rd_data_a (ring_short),
		.rd_data_b (ring_long)
	);

	assign old_short = fwd_short_s1 ? fwd_data_s1 : ring_short;
	assign old_long  = fwd_long_s1  ? fwd_data_s1 : ring_long;

	// Stage 1: slide both windows by one price.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_short_q <= '0;
			sum_long_q  <= '0;
		end else if (cfg_restart) begin
			sum_short_q <= '0;
			sum_long_q  <= '0;
		end else if (v_s1 && upd_s1) begin
			sum_short_q <= sum_short_q + SUM_W'(price_s1)
				- (sub_short_s1 ? SUM_W'(old_short) : '0);
			sum_long_q  <= sum_long_q + SUM_W'(price_s1)
				- (sub_long_s1 ? SUM_W'(old_long) : '0);
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: exact mean compare, short_sum * long > long_sum * short.
	// The sums already hold this bar's update while the bar is in stage 2.
	// ------------------------------------------------------------------
	assign prod_short = PROD_W'(sum_short_q) * PROD_W'(lp_q);
	assign prod_long  = PROD_W'(sum_long_q)  * PROD_W'(sp_q);
	assign now_above  = prod_short > prod_long;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			above_q <= 1'b0;
		end else if (cfg_restart) begin
			above_q <= 1'b0;
		end else if (v_s2 && upd_s2) begin
			above_q <= now_above;
		end
	end

	assign res_push       = v_s2 && upd_s2 && (op_s2 == OP_LIVE) && (now_above != above_q);
	assign res_data.stamp = time_s2;
	assign res_data.dir   = now_above ? DIR_BUY : DIR_SELL;

	// ------------------------------------------------------------------
	// Result queue and output port.
	// ------------------------------------------------------------------
	assign res_pop = out_valid && out_ready;

	mavx_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_data (res_data),
		.pop       (res_pop),
		.head      (res_head),
		.not_empty (out_valid),
		.count     (res_count)
	);

	// The user must change the symbol register only while no result is pending; the block does not enforce it.
	assign signal_time   = res_head.stamp;
	assign signal_symbol = sym_q;
	assign direction     = res_head.dir;

`ifndef ASSERT_OFF
	// The accept throttle keeps the result queue from overflowing.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> ((int'(res_count) < OUT_DEPTH) || out_ready))
		else $error("result queue overflow");

	// Warm-up is only ever declared with a full long window.
	a_warm_fill: assert property (@(posedge clk) disable iff (!arst_n)
		warm_q |-> (int'(fill_q) >= int'(lp_q)))
		else $error("warm flag set with short fill");

	// Until the ring wraps, the write pointer tracks the fill level.
	a_wp_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(fill_q) < MAX_LONG_WINDOW) |-> (wp_q == fill_q[RING_AW-1:0]))
		else $error("write pointer out of step with fill level");

	// Fill level saturates at the ring depth.
	a_fill_max: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (int'(fill_q) <= MAX_LONG_WINDOW))
		else $error("fill level beyond ring depth");
`endif

endmodule
`default_nettype wire
